[sv/ftds_pkg.sv]
package ftds_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned INT_W   = 31;
    localparam int unsigned FRAC_W  = 30;
    localparam int unsigned MAN_W   = 24;
    localparam int unsigned PROD_W  = MAN_W + FRAC_W;
    localparam int unsigned SHIFT_W = 6;
    localparam logic [SHIFT_W-1:0] SHIFT_CAP = SHIFT_W'(PROD_W + 1);
    localparam logic [7:0] EXP_SPECIAL = 8'hFF;
    localparam logic [7:0] EXP_BIAS_INT = 8'd150;
    localparam logic [7:0] EXP_OVF = 8'd158;
    localparam logic [INT_W-1:0] INT_SAT = {INT_W{1'b1}};

    typedef logic [FRAC_W-1:0] scale_t;

    // Powers of ten by digit count
    function automatic scale_t pow10(input logic [DIGIT_W-1:0] d);
        scale_t r;
        case (d)
            4'd0:    r = FRAC_W'(1);
            4'd1:    r = FRAC_W'(10);
            4'd2:    r = FRAC_W'(100);
            4'd3:    r = FRAC_W'(1000);
            4'd4:    r = FRAC_W'(10000);
            4'd5:    r = FRAC_W'(100000);
            4'd6:    r = FRAC_W'(1000000);
            4'd7:    r = FRAC_W'(10000000);
            4'd8:    r = FRAC_W'(100000000);
            default: r = FRAC_W'(1000000000);
        endcase
        return r;
    endfunction

endpackage

[sv/float_to_decimal_split.sv]
// Throughput: one transaction per cycle; the four stages advance together
// whenever the output register is empty or its result is being taken.
// Stages: decode and split, fraction times 10^digits, round and shift, carry.
// Reset (aresetn low, synchronous) clears all stage valid bits.
module float_to_decimal_split #(
    parameter int unsigned MAX_DIGITS = 9
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [31:0] value_bits, [35:32] digits, [39:36] zero
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] negative, [31:1] integer_part, [61:32] fraction_part, [62] overflow
    output logic [63:0] m_tdata
);
    import ftds_pkg::*;

    localparam logic [DIGIT_W-1:0] DMAX = DIGIT_W'(MAX_DIGITS);

    logic adv;
    assign adv = !m_tvalid || m_tready;
    assign s_tready = adv;

    // Stage 1: decode
    logic [VALUE_W-1:0] bits;
    logic [DIGIT_W-1:0] dig_in, dig_c;
    logic [7:0] ef;
    logic [MAN_W-1:0] man;
    logic [7:0] k_full;
    logic [7:0] e_pos;
    logic [INT_W-1:0] ip1_next;
    logic [MAN_W-1:0] f1_next;
    logic [SHIFT_W-1:0] k1_next;
    logic ovf1_next;

    assign bits   = s_tdata[31:0];
    assign dig_in = s_tdata[35:32];
    assign dig_c  = (dig_in > DMAX) ? DMAX : dig_in;
    assign ef     = bits[30:23];
    assign man    = (ef == 8'd0) ? {1'b0, bits[22:0]} : {1'b1, bits[22:0]};
    assign k_full = (ef == 8'd0) ? 8'd149 : (EXP_BIAS_INT - ef);
    assign e_pos  = ef - EXP_BIAS_INT;

    always_comb begin
        ovf1_next = 1'b0;
        ip1_next  = '0;
        f1_next   = '0;
        k1_next   = SHIFT_W'(1);
        if (ef == EXP_SPECIAL) begin
            ovf1_next = 1'b1;
        end else if (ef >= EXP_BIAS_INT) begin
            ovf1_next = (ef >= EXP_OVF) && (man != '0);
            ip1_next  = INT_W'(man) << e_pos[2:0];
        end else if (k_full >= 8'(MAN_W)) begin
            f1_next = man;
            k1_next = (k_full >= 8'(SHIFT_CAP)) ? SHIFT_CAP : k_full[SHIFT_W-1:0];
        end else begin
            ip1_next = INT_W'(man >> k_full[4:0]);
            f1_next  = man & ((MAN_W'(1) << k_full[4:0]) - MAN_W'(1));
            k1_next  = k_full[SHIFT_W-1:0];
        end
    end

    logic v1_reg, neg1_reg, ovf1_reg;
    logic [INT_W-1:0] ip1_reg;
    logic [MAN_W-1:0] f1_reg;
    logic [SHIFT_W-1:0] k1_reg;
    scale_t s1_reg;

    // Stage 2: scale fraction
    logic v2_reg, neg2_reg, ovf2_reg;
    logic [INT_W-1:0] ip2_reg;
    logic [PROD_W-1:0] p2_reg;
    logic [SHIFT_W-1:0] k2_reg;
    scale_t s2_reg;
    logic [PROD_W-1:0] p2_next;
    assign p2_next = PROD_W'(f1_reg) * PROD_W'(s1_reg);

    // Stage 3: round half-up and shift
    logic v3_reg, neg3_reg, ovf3_reg;
    logic [INT_W-1:0] ip3_reg;
    logic [FRAC_W:0] q3_reg;
    scale_t s3_reg;
    logic [PROD_W+1:0] sum3;
    logic [PROD_W+1:0] q3_wide;
    logic [FRAC_W:0] q3_next;
    assign sum3    = (PROD_W+2)'(p2_reg) + ((PROD_W+2)'(1) << (k2_reg - SHIFT_W'(1)));
    assign q3_wide = sum3 >> k2_reg;
    assign q3_next = q3_wide[FRAC_W:0];

    // Stage 4: carry into integer part, saturate
    logic v4_reg;
    logic [63:0] out_reg;
    logic [63:0] out_next;
    logic carry;
    assign carry = (q3_reg == {1'b0, s3_reg});
    always_comb begin
        out_next = '0;
        out_next[0] = neg3_reg;
        out_next[62] = ovf3_reg;
        if (ovf3_reg) begin
            out_next[31:1] = INT_SAT;
        end else if (carry) begin
            out_next[31:1] = ip3_reg + INT_W'(1);
        end else begin
            out_next[31:1]  = ip3_reg;
            out_next[61:32] = q3_reg[FRAC_W-1:0];
        end
    end

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Advance payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            neg1_reg <= bits[31];
            ovf1_reg <= ovf1_next;
            ip1_reg  <= ip1_next;
            f1_reg   <= f1_next;
            k1_reg   <= k1_next;
            s1_reg   <= pow10(dig_c);
            neg2_reg <= neg1_reg;
            ovf2_reg <= ovf1_reg;
            ip2_reg  <= ip1_reg;
            p2_reg   <= p2_next;
            k2_reg   <= k1_reg;
            s2_reg   <= s1_reg;
            neg3_reg <= neg2_reg;
            ovf3_reg <= ovf2_reg;
            ip3_reg  <= ip2_reg;
            q3_reg   <= q3_next;
            s3_reg   <= s2_reg;
            out_reg  <= out_next;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = out_reg;

endmodule
